### rtl/core/lpm_pkg.sv
`timescale 1ns / 1ps

package lpm_pkg;

    localparam int unsigned LPM_TABLE_DEPTH = 64;

    localparam int unsigned ENTRY_INDEX_W = 6;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned PORT_W        = 4;
    localparam int unsigned TTL_W         = 8;
    localparam int unsigned CHECKSUM_W    = 16;
    localparam int unsigned VERDICT_W     = 2;

    typedef enum logic {
        LPM_OP_WRITE  = 1'b0,
        LPM_OP_LOOKUP = 1'b1
    } lpm_op_t;

    typedef enum logic [VERDICT_W-1:0] {
        LPM_VERDICT_FORWARD     = 2'd0,
        LPM_VERDICT_TTL_EXPIRED = 2'd1,
        LPM_VERDICT_NO_ROUTE    = 2'd2,
        LPM_VERDICT_WRITTEN     = 2'd3
    } lpm_verdict_t;

    // Request as it travels down the cell chain. For a lookup, mask/hop/port
    // hold the best route found so far.
    typedef struct packed {
        logic                     is_write;
        logic [ENTRY_INDEX_W-1:0] idx;
        logic [ADDR_W-1:0]        addr;
        logic [ADDR_W-1:0]        mask;
        logic [ADDR_W-1:0]        hop;
        logic [PORT_W-1:0]        port;
        logic                     expired;
        logic                     found;
        logic [TTL_W-1:0]         ttl_out;
        logic [CHECKSUM_W-1:0]    chk_out;
    } lpm_req_t;

endpackage

### rtl/core/lpm_req_if.sv
`timescale 1ns / 1ps

interface lpm_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [5:0]  entry_index;
    logic [31:0] address;
    logic [31:0] mask;
    logic [31:0] hop_address;
    logic [3:0]  port;
    logic [7:0]  ttl;
    logic [15:0] header_checksum;

    modport source (
        output valid, opcode, entry_index, address, mask, hop_address, port, ttl,
               header_checksum,
        input  ready
    );

    modport sink (
        input  valid, opcode, entry_index, address, mask, hop_address, port, ttl,
               header_checksum,
        output ready
    );
endinterface

### rtl/core/lpm_rsp_if.sv
`timescale 1ns / 1ps

interface lpm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] next_hop_out;
    logic [3:0]  port_out;
    logic [7:0]  ttl_out;
    logic [15:0] checksum_out;

    modport source (
        output valid, verdict, next_hop_out, port_out, ttl_out, checksum_out,
        input  ready
    );

    modport sink (
        input  valid, verdict, next_hop_out, port_out, ttl_out, checksum_out,
        output ready
    );
endinterface

### rtl/core/lpm_cell.sv
`timescale 1ns / 1ps

module lpm_cell
    import lpm_pkg::*;
#(
    parameter int unsigned CELL_INDEX = 0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  logic     in_valid,
    input  lpm_req_t in_req,
    output logic     out_valid,
    output lpm_req_t out_req
);

    logic              entry_valid_reg;
    logic              entry_valid_next;
    logic [ADDR_W-1:0] prefix_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic [ADDR_W-1:0] hop_reg;
    logic [PORT_W-1:0] port_reg;

    logic              req_valid_reg;
    logic              req_valid_next;
    lpm_req_t          req_reg;
    lpm_req_t          req_next;

    logic              wr_hit;
    logic              match;
    logic              take;

    always_comb
    begin
        wr_hit = advance && in_valid && in_req.is_write &&
                 (32'(in_req.idx) == 32'(CELL_INDEX));
        match  = entry_valid_reg && !in_req.is_write && !in_req.expired &&
                 ((in_req.addr & mask_reg) == prefix_reg);
        take   = match && (!in_req.found || (mask_reg > in_req.mask));
    end

    always_comb
    begin
        entry_valid_next = entry_valid_reg | wr_hit;
        req_valid_next   = advance ? in_valid : req_valid_reg;
        req_next         = in_req;
        if (take)
        begin
            req_next.found = 1'b1;
            req_next.mask  = mask_reg;
            req_next.hop   = hop_reg;
            req_next.port  = port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            req_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            req_valid_reg   <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            prefix_reg <= in_req.addr;
            mask_reg   <= in_req.mask;
            hop_reg    <= in_req.hop;
            port_reg   <= in_req.port;
        end
        if (advance)
        begin
            req_reg <= req_next;
        end
    end

    assign out_valid = req_valid_reg;
    assign out_req   = req_reg;

endmodule

### rtl/core/longest_prefix_route_lookup_top.sv
`timescale 1ns / 1ps
// Requests pass through the registered cell chain and then the output register.
// Throughput: one request per cycle while rsp is not stalled; each cell of the
// chain holds one route and checks one passing request per cycle, in table order.
// Reset (rst_n, async, active low) clears route valid bits and pipeline
// valids; route contents are undefined until written.

module longest_prefix_route_lookup_top
    import lpm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = LPM_TABLE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    lpm_req_if.sink       req,
    lpm_rsp_if.source     rsp
);

    logic                  advance;
    logic                  chain_valid [TABLE_DEPTH+1];
    lpm_req_t              chain_req   [TABLE_DEPTH+1];

    logic [CHECKSUM_W:0]   chk_sum0;
    logic [CHECKSUM_W:0]   chk_sum1;
    logic [CHECKSUM_W:0]   chk_sum2;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    lpm_verdict_t          verdict_reg;
    lpm_verdict_t          verdict_next;
    logic [ADDR_W-1:0]     hop_reg;
    logic [ADDR_W-1:0]     hop_next;
    logic [PORT_W-1:0]     port_reg;
    logic [PORT_W-1:0]     port_next;
    logic [TTL_W-1:0]      ttl_reg;
    logic [TTL_W-1:0]      ttl_next;
    logic [CHECKSUM_W-1:0] chk_reg;
    logic [CHECKSUM_W-1:0] chk_next;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    // TTL shares its word with protocol: word drops by 0x0100 (RFC 1624 eqn 3)
    always_comb
    begin
        chk_sum0 = {1'b0, ~req.header_checksum} + 17'h0FEFF;
        chk_sum1 = {1'b0, chk_sum0[CHECKSUM_W-1:0]} + 17'(chk_sum0[CHECKSUM_W]);
        chk_sum2 = {1'b0, chk_sum1[CHECKSUM_W-1:0]} + 17'(chk_sum1[CHECKSUM_W]);
    end

    always_comb
    begin
        chain_valid[0]       = req.valid;
        chain_req[0].is_write = (lpm_op_t'(req.opcode) == LPM_OP_WRITE);
        chain_req[0].idx     = req.entry_index;
        chain_req[0].addr    = req.address;
        chain_req[0].mask    = chain_req[0].is_write ? req.mask : '0;
        chain_req[0].hop     = chain_req[0].is_write ? req.hop_address : '0;
        chain_req[0].port    = chain_req[0].is_write ? req.port : '0;
        chain_req[0].expired = (req.ttl <= 8'd1);
        chain_req[0].found   = 1'b0;
        chain_req[0].ttl_out = req.ttl - 8'd1;
        chain_req[0].chk_out = ~chk_sum2[CHECKSUM_W-1:0];
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        lpm_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[g]),
            .in_req    (chain_req[g]),
            .out_valid (chain_valid[g+1]),
            .out_req   (chain_req[g+1])
        );
    end

    always_comb
    begin
        out_valid_next = advance ? chain_valid[TABLE_DEPTH] : out_valid_reg;
    end

    always_comb
    begin
        hop_next  = '0;
        port_next = '0;
        ttl_next  = '0;
        chk_next  = '0;
        priority if (chain_req[TABLE_DEPTH].is_write)
        begin
            verdict_next = LPM_VERDICT_WRITTEN;
        end
        else if (chain_req[TABLE_DEPTH].expired)
        begin
            verdict_next = LPM_VERDICT_TTL_EXPIRED;
        end
        else if (chain_req[TABLE_DEPTH].found)
        begin
            verdict_next = LPM_VERDICT_FORWARD;
            hop_next     = chain_req[TABLE_DEPTH].hop;
            port_next    = chain_req[TABLE_DEPTH].port;
            ttl_next     = chain_req[TABLE_DEPTH].ttl_out;
            chk_next     = chain_req[TABLE_DEPTH].chk_out;
        end
        else
        begin
            verdict_next = LPM_VERDICT_NO_ROUTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            verdict_reg <= verdict_next;
            hop_reg     <= hop_next;
            port_reg    <= port_next;
            ttl_reg     <= ttl_next;
            chk_reg     <= chk_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.verdict      = verdict_reg;
    assign rsp.next_hop_out = hop_reg;
    assign rsp.port_out     = port_reg;
    assign rsp.ttl_out      = ttl_reg;
    assign rsp.checksum_out = chk_reg;

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("request accepted while response stalled");

    a_forward_ttl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.verdict == LPM_VERDICT_FORWARD)) |-> (rsp.ttl_out != 8'd0))
        else $error("forwarded with expired ttl");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.verdict != LPM_VERDICT_FORWARD)) |->
        ((rsp.next_hop_out == '0) && (rsp.port_out == '0) &&
         (rsp.ttl_out == '0) && (rsp.checksum_out == '0)))
        else $error("non-forward response carries route data");
`endif

endmodule

### tb/tb_longest_prefix_route_lookup_top.sv
`timescale 1ns / 1ps

module tb_longest_prefix_route_lookup_top;
    import lpm_pkg::*;

    typedef struct packed {
        lpm_op_t     op;
        logic [5:0]  slot;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [31:0] hop;
        logic [3:0]  port;
        logic [7:0]  ttl;
        logic [15:0] chk;
    } route_req_t;

    typedef struct packed {
        lpm_verdict_t verdict;
        logic [31:0]  hop;
        logic [3:0]   port;
        logic [7:0]   ttl;
        logic [15:0]  chk;
    } route_rsp_t;

    typedef struct packed {
        route_req_t req;
        logic       typed;
        route_rsp_t rsp;
    } route_row_t;

    localparam int RANDOM_REQUESTS = 550;

    logic clk = 1'b0;
    logic rst_n;

    lpm_req_if req ();
    lpm_rsp_if rsp ();

    longest_prefix_route_lookup_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow route table
    logic        route_valid  [LPM_TABLE_DEPTH];
    logic [31:0] route_prefix [LPM_TABLE_DEPTH];
    logic [31:0] route_mask   [LPM_TABLE_DEPTH];
    logic [31:0] route_hop    [LPM_TABLE_DEPTH];
    logic [3:0]  route_port   [LPM_TABLE_DEPTH];

    route_rsp_t pending_rsp_q [$];
    route_row_t directed_rows [$];

    int  mismatch_count = 0;
    int  checked_count  = 0;
    int  written_count  = 0;
    int  forward_count  = 0;
    int  expired_count  = 0;
    int  noroute_count  = 0;
    bit  steady_run     = 1'b0;

    function automatic logic [15:0] checksum_after_ttl_dec(logic [15:0] hc);
        logic [16:0] sum;
        logic [15:0] folded;
        sum    = {1'b0, ~hc} + 17'h0FEFF;
        folded = sum[15:0] + {15'd0, sum[16]};
        return ~folded;
    endfunction

    function automatic route_rsp_t route_lookup_predict(route_req_t r);
        route_rsp_t o;
        bit         hit;
        int         best;
        o    = '0;
        hit  = 1'b0;
        best = 0;
        if (r.op == LPM_OP_WRITE)
        begin
            if (r.slot < LPM_TABLE_DEPTH)
            begin
                route_valid[r.slot]  = 1'b1;
                route_prefix[r.slot] = r.addr;
                route_mask[r.slot]   = r.mask;
                route_hop[r.slot]    = r.hop;
                route_port[r.slot]   = r.port;
            end
            o.verdict = LPM_VERDICT_WRITTEN;
            return o;
        end
        if (r.ttl <= 8'd1)
        begin
            o.verdict = LPM_VERDICT_TTL_EXPIRED;
            return o;
        end
        for (int i = 0; i < LPM_TABLE_DEPTH; i++)
        begin
            if (route_valid[i] && ((r.addr & route_mask[i]) == route_prefix[i]))
            begin
                if (!hit || route_mask[i] > route_mask[best])
                begin
                    hit  = 1'b1;
                    best = i;
                end
            end
        end
        if (!hit)
        begin
            o.verdict = LPM_VERDICT_NO_ROUTE;
            return o;
        end
        o.verdict = LPM_VERDICT_FORWARD;
        o.hop     = route_hop[best];
        o.port    = route_port[best];
        o.ttl     = r.ttl - 8'd1;
        o.chk     = checksum_after_ttl_dec(r.chk);
        return o;
    endfunction

    function automatic route_req_t mk_req(lpm_op_t op, logic [5:0] slot, logic [31:0] addr,
                                          logic [31:0] mask, logic [31:0] hop,
                                          logic [3:0] port, logic [7:0] ttl,
                                          logic [15:0] chk);
        route_req_t r;
        r.op   = op;
        r.slot = slot;
        r.addr = addr;
        r.mask = mask;
        r.hop  = hop;
        r.port = port;
        r.ttl  = ttl;
        r.chk  = chk;
        return r;
    endfunction

    function automatic route_rsp_t verdict_only(lpm_verdict_t v);
        route_rsp_t o;
        o         = '0;
        o.verdict = v;
        return o;
    endfunction

    function automatic void add_row(route_req_t r, logic typed, route_rsp_t e);
        route_row_t row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = e;
        directed_rows.push_back(row);
    endfunction

    function automatic route_req_t random_request();
        route_req_t  r;
        logic [31:0] ones;
        int          plen;
        int          s;
        ones   = '1;
        r.op   = ($urandom_range(99) < 25) ? LPM_OP_WRITE : LPM_OP_LOOKUP;
        r.slot = 6'(($urandom_range(99) < 30) ? $urandom_range(7) : $urandom_range(63));
        r.addr = $urandom;
        r.mask = $urandom;
        r.hop  = $urandom;
        r.port = 4'($urandom_range(15));
        r.ttl  = 8'($urandom_range(255));
        r.chk  = 16'($urandom_range(16'hFFFF));
        if (r.op == LPM_OP_WRITE)
        begin
            if ($urandom_range(99) < 90)
            begin
                if ($urandom_range(99) < 40)
                    plen = 8 * $urandom_range(1, 3);
                else
                    plen = $urandom_range(32);
                r.mask = (plen == 0) ? 32'h0 : ones << (32 - plen);
            end
            if ($urandom_range(99) < 90)
                r.addr = r.addr & r.mask;
        end
        else
        begin
            case ($urandom_range(19))
                0, 1:    r.ttl = 8'($urandom_range(1));
                2:       r.ttl = 8'hFF;
                default: r.ttl = 8'($urandom_range(2, 255));
            endcase
            if ($urandom_range(99) < 75)
            begin
                s = $urandom_range(63);
                for (int n = 0; n < LPM_TABLE_DEPTH && !route_valid[s]; n++)
                    s = (s + 1) % LPM_TABLE_DEPTH;
                if (route_valid[s])
                    r.addr = (route_prefix[s] & route_mask[s]) | ($urandom & ~route_mask[s]);
            end
        end
        return r;
    endfunction

    task automatic send_request(route_req_t r, logic typed, route_rsp_t typed_rsp);
        route_rsp_t pred;
        if (!steady_run)
        begin
            while ($urandom_range(99) < 34)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req.valid           <= 1'b1;
        req.opcode          <= r.op;
        req.entry_index     <= r.slot;
        req.address         <= r.addr;
        req.mask            <= r.mask;
        req.hop_address     <= r.hop;
        req.port            <= r.port;
        req.ttl             <= r.ttl;
        req.header_checksum <= r.chk;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pred = route_lookup_predict(r);
        pending_rsp_q.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic drain_responses();
        req.valid <= 1'b0;
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // response side: random backpressure and checking
    always @(posedge clk)
    begin
        route_rsp_t got;
        route_rsp_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            rsp.ready <= steady_run ? 1'b1 : ($urandom_range(99) >= 34);
            if (rsp.valid && rsp.ready)
            begin
                got.verdict = lpm_verdict_t'(rsp.verdict);
                got.hop     = rsp.next_hop_out;
                got.port    = rsp.port_out;
                got.ttl     = rsp.ttl_out;
                got.chk     = rsp.checksum_out;
                if (pending_rsp_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: unexpected response verdict=%0d hop=%h port=%0d",
                                 got.verdict, got.hop, got.port);
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    checked_count++;
                    case (want.verdict)
                        LPM_VERDICT_WRITTEN:     written_count++;
                        LPM_VERDICT_FORWARD:     forward_count++;
                        LPM_VERDICT_TTL_EXPIRED: expired_count++;
                        default:                 noroute_count++;
                    endcase
                    if (got.verdict !== want.verdict || got.hop !== want.hop ||
                        got.port !== want.port || got.ttl !== want.ttl ||
                        got.chk !== want.chk)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"ERROR: response %0d expected verdict=%0d hop=%h ",
                                      "port=%0d ttl=%0d chk=%h, got verdict=%0d hop=%h ",
                                      "port=%0d ttl=%0d chk=%h"},
                                     checked_count, want.verdict, want.hop, want.port,
                                     want.ttl, want.chk, got.verdict, got.hop, got.port,
                                     got.ttl, got.chk);
                    end
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        route_rsp_t fwd_rsp;
        int         leftover;

        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.opcode          = LPM_OP_WRITE;
        req.entry_index     = '0;
        req.address         = '0;
        req.mask            = '0;
        req.hop_address     = '0;
        req.port            = '0;
        req.ttl             = '0;
        req.header_checksum = '0;
        for (int i = 0; i < LPM_TABLE_DEPTH; i++)
        begin
            route_valid[i]  = 1'b0;
            route_prefix[i] = '0;
            route_mask[i]   = '0;
            route_hop[i]    = '0;
            route_port[i]   = '0;
        end

        fwd_rsp         = verdict_only(LPM_VERDICT_FORWARD);
        fwd_rsp.hop     = 32'hC0A8_0001;
        fwd_rsp.port    = 4'd1;
        fwd_rsp.ttl     = 8'hFE;
        fwd_rsp.chk     = 16'h0100;

        // empty table, TTL edge cases
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0A00_0001, 32'h0, 32'h0, 4'd0, 8'd64, 16'h1234),
                1'b1, verdict_only(LPM_VERDICT_NO_ROUTE));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd63, 32'hFFFF_FFFF, '1, '1, 4'hF, 8'd0, 16'hFFFF),
                1'b1, verdict_only(LPM_VERDICT_TTL_EXPIRED));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0, 32'h0, 32'h0, 4'd0, 8'd1, 16'h0),
                1'b1, verdict_only(LPM_VERDICT_TTL_EXPIRED));
        // default route
        add_row(mk_req(LPM_OP_WRITE, 6'd0, 32'h0, 32'h0, 32'hC0A8_0001, 4'd1, 8'd0, 16'h0),
                1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0, 8'd255, 16'h0),
                1'b1, fwd_rsp);
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0, 32'h0, 32'h0, 4'd0, 8'd2, 16'hFFFF),
                1'b0, '0);
        add_row(mk_req(LPM_OP_WRITE, 6'd63, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'd15,
                       8'd255, 16'hFFFF), 1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        // equal masks: lower slot wins
        add_row(mk_req(LPM_OP_WRITE, 6'd10, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_000A, 4'd3,
                       8'd0, 16'h0), 1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        add_row(mk_req(LPM_OP_WRITE, 6'd5, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0005, 4'd7,
                       8'd0, 16'h0), 1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0A01_2345, 32'h0, 32'h0, 4'd0, 8'd64, 16'hB1E6),
                1'b0, '0);
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0A02_0000, 32'h0, 32'h0, 4'd0, 8'd17, 16'h8000),
                1'b0, '0);
        // host route
        add_row(mk_req(LPM_OP_WRITE, 6'd20, 32'h0A01_0203, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,
                       8'd0, 16'h0), 1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0A01_0203, 32'h0, 32'h0, 4'd0, 8'd3, 16'h0001),
                1'b0, '0);
        // prefix with bits outside its mask never matches
        add_row(mk_req(LPM_OP_WRITE, 6'd30, 32'h0B00_00FF, 32'hFF00_0000, 32'h0B00_0001, 4'd9,
                       8'd0, 16'h0), 1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0B00_00FF, 32'h0, 32'h0, 4'd0, 8'd100, 16'h7FFF),
                1'b0, '0);
        // replace the default route
        add_row(mk_req(LPM_OP_WRITE, 6'd0, 32'hC000_0000, 32'hE000_0000, 32'h5555_AAAA, 4'd6,
                       8'd0, 16'h0), 1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0B00_0000, 32'h0, 32'h0, 4'd0, 8'd50, 16'h4321),
                1'b1, verdict_only(LPM_VERDICT_NO_ROUTE));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'hDFFF_FFFF, 32'h0, 32'h0, 4'd0, 8'd128, 16'h1234),
                1'b0, '0);
        // non-contiguous mask
        add_row(mk_req(LPM_OP_WRITE, 6'd40, 32'h0A00_0100, 32'hFF00_FF00, 32'hAAAA_5555, 4'd2,
                       8'd0, 16'h0), 1'b1, verdict_only(LPM_VERDICT_WRITTEN));
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0A55_0100, 32'h0, 32'h0, 4'd0, 8'd255, 16'hFFFF),
                1'b0, '0);
        add_row(mk_req(LPM_OP_LOOKUP, 6'd0, 32'h0A01_0000, 32'h0, 32'h0, 4'd0, 8'd2, 16'hFEFF),
                1'b0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
        drain_responses();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            steady_run = (n >= 200 && n < 320);
            if (n == 400)
                drain_responses();
            send_request(random_request(), 1'b0, '0);
        end
        steady_run = 1'b0;

        drain_responses();
        repeat (LPM_TABLE_DEPTH + 16) @(posedge clk);

        leftover = pending_rsp_q.size();
        $display("Checked %0d responses: %0d route writes, %0d forwarded,",
                 checked_count, written_count, forward_count);
        $display("%0d TTL expired, %0d no route; %0d mismatches",
                 expired_count, noroute_count, mismatch_count);
        if (mismatch_count == 0 && leftover == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
